/* sv/ncc_pkg.sv */
package ncc_pkg;

    localparam int MAX_LEN_DEF   = 1024;
    localparam int FRAC_BITS_DEF = 15;

    localparam int SAMPLE_W  = 16;
    localparam int MAX_LAG_W = 10;
    localparam int LAG_W     = 11;
    localparam int CONF_W    = 16;

    localparam logic [MAX_LAG_W-1:0] MAX_LAG_RST = MAX_LAG_W'(30);

    typedef struct packed {
        logic                     overflow;
        logic [CONF_W-1:0]        confidence;
        logic signed [LAG_W-1:0]  best_lag;
    } t_res;

endpackage

/* sv/ncc_ram.sv */
module ncc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ncc_front.sv */
module ncc_front #(
    parameter int MAX_LEN = ncc_pkg::MAX_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ncc_pkg::SAMPLE_W-1:0]        i_first,
    input  logic [ncc_pkg::SAMPLE_W-1:0]        i_second,
    input  logic                                i_last,
    input  logic                                i_q_full,
    input  logic                                i_release,
    output logic                                o_push,
    output logic [$clog2(MAX_LEN+1)-1:0]        o_len,
    output logic                                o_ovf,
    output logic                                o_we,
    output logic [$clog2(MAX_LEN)-1:0]          o_waddr,
    output logic [2*ncc_pkg::SAMPLE_W-1:0]      o_wdata
);

    localparam int LW = $clog2(MAX_LEN+1);
    localparam int AW = $clog2(MAX_LEN);

    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_hold, n_hold;
    logic          acc, full;

    assign o_ready = !r_hold && !i_q_full;
    assign acc     = i_valid && o_ready;
    assign full    = (r_cnt == LW'(MAX_LEN));

    assign o_we    = acc && !full;
    assign o_waddr = r_cnt[AW-1:0];
    assign o_wdata = {i_second, i_first};
    assign o_push  = acc && i_last;
    assign o_len   = full ? r_cnt : r_cnt + LW'(1);
    assign o_ovf   = r_ovf || full;

    always_comb begin
        n_cnt  = r_cnt;
        n_ovf  = r_ovf;
        n_hold = r_hold;
        if (i_release) begin
            n_hold = 1'b0;
        end
        if (acc) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_cnt = r_cnt + LW'(1);
            end
            // hold the store until the search is done with it
            if (i_last) begin
                n_cnt  = '0;
                n_ovf  = 1'b0;
                n_hold = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            r_hold <= n_hold;
        end
    end

endmodule

/* sv/ncc_jobq.sv */
module ncc_jobq #(
    parameter int WIDTH = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_ent [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_num;

    assign o_full  = (r_num == 2'd2);
    assign o_empty = (r_num == 2'd0);
    assign o_data  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_num <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_num <= r_num + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* sv/ncc_mul.sv */
module ncc_mul #(
    parameter int OPW = 54
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [OPW-1:0]   i_a,
    input  logic [OPW-1:0]   i_b,
    output logic             o_done,
    output logic [2*OPW-1:0] o_prod
);

    localparam int CNW = $clog2(OPW+1);

    logic [2*OPW-1:0] r_a, r_acc;
    logic [OPW-1:0]   r_b;
    logic [CNW-1:0]   r_cnt;
    logic             r_busy, r_done;

    // one multiplier bit per cycle, shift and add
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a   <= (2*OPW)'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= CNW'(OPW);
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNW'(1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* sv/ncc_back.sv */
module ncc_back #(
    parameter int MAX_LEN   = ncc_pkg::MAX_LEN_DEF,
    parameter int FRAC_BITS = ncc_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ncc_pkg::MAX_LAG_W-1:0]    i_max_lag,
    input  logic                             i_q_empty,
    input  logic [$clog2(MAX_LEN+1)-1:0]     i_len,
    input  logic                             i_ovf,
    output logic                             o_pop,
    output logic                             o_release,
    output logic [$clog2(MAX_LEN)-1:0]       o_raddr_x,
    output logic [$clog2(MAX_LEN)-1:0]       o_raddr_y,
    input  logic [ncc_pkg::SAMPLE_W-1:0]     i_rdata_x,
    input  logic [ncc_pkg::SAMPLE_W-1:0]     i_rdata_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output ncc_pkg::t_res                    o_res
);

    localparam int SW   = ncc_pkg::SAMPLE_W;
    localparam int LW   = $clog2(MAX_LEN+1);
    localparam int AW   = $clog2(MAX_LEN);
    localparam int MLW  = ncc_pkg::MAX_LAG_W;
    localparam int GW   = ncc_pkg::LAG_W;
    localparam int RW   = (MLW > LW) ? MLW : LW;
    localparam int SUMW = SW + LW;
    localparam int SQW  = 2*SW + LW;
    localparam int DW   = 2*SW + 2*LW;
    localparam int PW   = 2*DW;
    localparam int QW   = FRAC_BITS + 1;
    localparam int CW   = FRAC_BITS + 2;
    localparam int TW   = 2*QW + PW;
    localparam int KW   = $clog2(QW+1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LAG  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_MST  = 4'd3;
    localparam logic [3:0] S_MWT  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_NEXT = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [2:0] OP_MSXX = 3'd0;
    localparam logic [2:0] OP_SXSX = 3'd1;
    localparam logic [2:0] OP_MSYY = 3'd2;
    localparam logic [2:0] OP_SYSY = 3'd3;
    localparam logic [2:0] OP_MSXY = 3'd4;
    localparam logic [2:0] OP_SXSY = 3'd5;
    localparam logic [2:0] OP_D1D2 = 3'd6;
    localparam logic [2:0] OP_MAG  = 3'd7;

    logic [3:0]             r_st;
    logic [LW-1:0]          r_n, r_m, r_s1, r_s2, r_idx;
    logic                   r_ovf;
    logic [MLW-1:0]         r_r;
    logic signed [GW-1:0]   r_lag, r_best_lag;
    logic signed [CW-1:0]   r_best;
    logic                   r_v1, r_v2;
    logic [SW-1:0]          r_x, r_y;
    logic [2*SW-1:0]        r_pxx, r_pyy, r_pxy;
    logic [SUMW-1:0]        r_sx, r_sy;
    logic [SQW-1:0]         r_sxx, r_syy, r_sxy;
    logic [2:0]             r_op;
    logic [PW-1:0]          r_t0, r_p;
    logic [DW-1:0]          r_d1, r_d2, r_mag;
    logic                   r_neg;
    logic [TW-1:0]          r_l, r_t, r_v, r_ps;
    logic [QW-1:0]          r_q;
    logic [KW-1:0]          r_k;
    logic                   r_ovalid, r_rel;
    ncc_pkg::t_res          r_res;

    logic                   mul_start, mul_done;
    logic [DW-1:0]          mul_a, mul_b;
    logic [PW-1:0]          mul_p;
    logic [RW-1:0]          r_cand;
    logic [MLW-1:0]         al;
    logic [LW-1:0]          m_cur;
    logic [LW-1:0]          ax, ay;
    logic [TW-1:0]          trial;
    logic signed [CW-1:0]   cq, cval;
    logic                   issue;
    logic                   out_go;

    ncc_mul #(.OPW(DW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    always_comb begin
        case (r_op)
            OP_MSXX: begin mul_a = DW'(r_m);   mul_b = DW'(r_sxx); end
            OP_SXSX: begin mul_a = DW'(r_sx);  mul_b = DW'(r_sx);  end
            OP_MSYY: begin mul_a = DW'(r_m);   mul_b = DW'(r_syy); end
            OP_SYSY: begin mul_a = DW'(r_sy);  mul_b = DW'(r_sy);  end
            OP_MSXY: begin mul_a = DW'(r_m);   mul_b = DW'(r_sxy); end
            OP_SXSY: begin mul_a = DW'(r_sx);  mul_b = DW'(r_sy);  end
            OP_D1D2: begin mul_a = r_d1;       mul_b = r_d2;       end
            default: begin mul_a = r_mag;      mul_b = r_mag;      end
        endcase
    end

    assign mul_start = (r_st == S_MST);
    assign r_cand    = (RW'(i_max_lag) < RW'(i_len >> 2)) ? RW'(i_max_lag) : RW'(i_len >> 2);
    assign al        = r_lag[GW-1] ? MLW'(-r_lag) : MLW'(r_lag);
    assign m_cur     = r_n - LW'(al);
    assign ax        = r_s1 + r_idx;
    assign ay        = r_s2 + r_idx;
    assign o_raddr_x = ax[AW-1:0];
    assign o_raddr_y = ay[AW-1:0];
    assign issue     = (r_st == S_ACC) && (r_idx != r_m);
    assign trial     = r_t + r_v + r_ps;
    assign cq        = CW'(r_q);
    assign cval      = r_neg ? -cq : cq;
    assign out_go    = (r_st == S_OUT) && (!r_ovalid || i_ready);
    assign o_pop     = (r_st == S_IDLE) && !i_q_empty;
    assign o_release = r_rel;
    assign o_valid   = r_ovalid;
    assign o_res     = r_res;

    // sample pipeline: read, square and multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_x   <= i_rdata_x;
        r_y   <= i_rdata_y;
        r_pxx <= i_rdata_x * i_rdata_x;
        r_pyy <= i_rdata_y * i_rdata_y;
        r_pxy <= i_rdata_x * i_rdata_y;
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_n        <= i_len;
                r_ovf      <= i_ovf;
                r_r        <= MLW'(r_cand);
                r_lag      <= -GW'(r_cand);
                r_best     <= -CW'(1 << FRAC_BITS);
                r_best_lag <= '0;
            end
            S_LAG: begin
                r_m   <= m_cur;
                r_s1  <= r_lag[GW-1] ? LW'(al) : '0;
                r_s2  <= r_lag[GW-1] ? '0 : LW'(al);
                r_idx <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxx <= '0;
                r_syy <= '0;
                r_sxy <= '0;
                r_op  <= OP_MSXX;
            end
            S_ACC: begin
                if (issue) begin
                    r_idx <= r_idx + LW'(1);
                end
                if (r_v2) begin
                    r_sx  <= r_sx + SUMW'(r_x);
                    r_sy  <= r_sy + SUMW'(r_y);
                    r_sxx <= r_sxx + SQW'(r_pxx);
                    r_syy <= r_syy + SQW'(r_pyy);
                    r_sxy <= r_sxy + SQW'(r_pxy);
                end
            end
            S_MWT: begin
                if (mul_done) begin
                    r_op <= r_op + 3'd1;
                    case (r_op)
                        OP_SXSX: r_d1 <= DW'(r_t0 - mul_p);
                        OP_SYSY: r_d2 <= DW'(r_t0 - mul_p);
                        OP_SXSY: begin
                            // zero variance: correlation counts as zero
                            r_neg <= (r_t0 < mul_p) && (r_d1 != '0) && (r_d2 != '0);
                            r_mag <= (r_t0 < mul_p) ? DW'(mul_p - r_t0) : DW'(r_t0 - mul_p);
                            r_q   <= '0;
                        end
                        OP_D1D2: r_p <= mul_p;
                        OP_MAG: begin
                            r_l  <= TW'(mul_p) << (2*FRAC_BITS);
                            r_ps <= TW'(r_p) << (2*FRAC_BITS);
                            r_t  <= '0;
                            r_v  <= '0;
                            r_k  <= KW'(QW);
                        end
                        default: r_t0 <= mul_p;
                    endcase
                end
            end
            S_SQRT: begin
                // build the quotient one bit a step, largest q with q*q*d1*d2 <= L
                if (trial <= r_l) begin
                    r_t <= trial;
                    r_v <= (r_v + (r_ps << 1)) >> 1;
                    r_q <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_v <= r_v >> 1;
                    r_q <= {r_q[QW-2:0], 1'b0};
                end
                r_ps <= r_ps >> 2;
                r_k  <= r_k - KW'(1);
            end
            S_CMP: begin
                if (cval > r_best) begin
                    r_best     <= cval;
                    r_best_lag <= r_lag;
                end
            end
            S_NEXT: begin
                r_lag <= r_lag + GW'(1);
            end
            default: begin
            end
        endcase
        if (out_go) begin
            r_res.best_lag   <= r_best_lag;
            r_res.confidence <= (r_best > 0) ? ncc_pkg::CONF_W'(r_best) : '0;
            r_res.overflow   <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ovalid <= 1'b0;
            r_rel    <= 1'b0;
        end else begin
            r_v1  <= issue;
            r_v2  <= r_v1;
            r_rel <= out_go;
            if (out_go) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_IDLE: if (!i_q_empty) r_st <= S_LAG;
                S_LAG: begin
                    if (m_cur < (r_n >> 1)) begin
                        r_st <= S_NEXT;
                    end else begin
                        r_st <= S_ACC;
                    end
                end
                S_ACC: if (!issue && !r_v1 && !r_v2) r_st <= S_MST;
                S_MST: r_st <= S_MWT;
                S_MWT: begin
                    if (mul_done) begin
                        if (r_op == OP_SXSY && (r_d1 == '0 || r_d2 == '0)) begin
                            r_st <= S_CMP;
                        end else if (r_op == OP_MAG) begin
                            r_st <= S_SQRT;
                        end else begin
                            r_st <= S_MST;
                        end
                    end
                end
                S_SQRT: if (r_k == KW'(1)) r_st <= S_CMP;
                S_CMP:  r_st <= S_NEXT;
                S_NEXT: begin
                    if (r_lag == $signed(GW'(r_r))) begin
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_LAG;
                    end
                end
                S_OUT: begin
                    if (out_go) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

/* sv/ncc_lag_search_unit.sv */
// Normalized cross-correlation lag search.
// Input stream: one word per pair of samples, first sequence in tdata[15:0],
// second in tdata[31:16]; tlast marks the final pair and starts the search.
// Pairs load at one per cycle while tready is high into two sample memories
// of MAX_LEN entries; pairs beyond MAX_LEN are dropped and flagged in the result.
// After the final pair tready stays low until the search has finished with
// the memories. For each lag from -R to +R, R = min(max_lag, n/4), the search
// streams the overlap, runs up to eight products through one shift-add
// multiplier of DW bits, DW = 32 + 2*clog2(MAX_LEN+1), and builds the
// square-root quotient of FRAC_BITS + 1 bits. Lags with an overlap under n/2
// are skipped.
// The result word goes to an output register; when the receiver stalls, it
// holds there and the next search stops at its end until the word is taken,
// while loading of the next sequences goes on.
// The cfg channel writes max_lag (reset 30); it is always ready.
// Reset clears counters, flags and handshakes; memory contents stay undefined.
module ncc_lag_search_unit #(
    parameter int MAX_LEN   = ncc_pkg::MAX_LEN_DEF,
    parameter int FRAC_BITS = ncc_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] sample_first, [31:16] sample_second
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [10:0] best_lag, [26:11] confidence,
                                          // [27] overflow, [31:28] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data        // max_lag
);

    localparam int SW = ncc_pkg::SAMPLE_W;
    localparam int LW = $clog2(MAX_LEN+1);
    localparam int AW = $clog2(MAX_LEN);

    logic [ncc_pkg::MAX_LAG_W-1:0] r_max_lag;
    logic                          push, pop, q_full, q_empty, release_st;
    logic [LW-1:0]                 push_len, job_len;
    logic                          push_ovf, job_ovf;
    logic                          we;
    logic [AW-1:0]                 waddr, raddr_x, raddr_y;
    logic [2*SW-1:0]               wdata;
    logic [SW-1:0]                 rdata_x, rdata_y;
    ncc_pkg::t_res                 res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag <= ncc_pkg::MAX_LAG_RST;
        end else if (i_cfg_valid) begin
            r_max_lag <= i_cfg_data;
        end
    end

    ncc_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_first   (i_s_axis_tdata[15:0]),
        .i_second  (i_s_axis_tdata[31:16]),
        .i_last    (i_s_axis_tlast),
        .i_q_full  (q_full),
        .i_release (release_st),
        .o_push    (push),
        .o_len     (push_len),
        .o_ovf     (push_ovf),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    ncc_jobq #(.WIDTH(LW + 1)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ovf, push_len}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  ({job_ovf, job_len})
    );

    ncc_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata[SW-1:0]),
        .i_raddr (raddr_x),
        .o_rdata (rdata_x)
    );

    ncc_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata[2*SW-1:SW]),
        .i_raddr (raddr_y),
        .o_rdata (rdata_y)
    );

    ncc_back #(.MAX_LEN(MAX_LEN), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_lag (r_max_lag),
        .i_q_empty (q_empty),
        .i_len     (job_len),
        .i_ovf     (job_ovf),
        .o_pop     (pop),
        .o_release (release_st),
        .o_raddr_x (raddr_x),
        .o_raddr_y (raddr_y),
        .i_rdata_x (rdata_x),
        .i_rdata_y (rdata_y),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (res)
    );

    assign o_m_axis_tdata = {4'b0, res};

    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input taken while search owns the store");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("job queue overrun");

    a_release_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_st |-> o_m_axis_tvalid)
        else $error("store released without a result word");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("job queue underrun");

endmodule
